[design/cfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CSR_WIDTH = 16;
   localparam int OUT_LEN_WIDTH = 16;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 16'hFFFF;
   localparam logic [BYTE_WIDTH-1:0] FULL_CODE = 8'hFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = 1;
   localparam int QUEUE_CNT_WIDTH = 2;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_ZERO_CODE     = 3'd1,
      STATUS_ZERO_IN_BLOCK = 3'd2,
      STATUS_TRUNCATED     = 3'd3,
      STATUS_OVERFLOW      = 3'd4
   } status_type;

   // Everything one request leaves for the output side: an optional data byte
   // followed by an optional end-of-frame status.
   typedef struct packed {
      logic                     data_vld;
      logic [BYTE_WIDTH-1:0]    data;
      logic                     done_vld;
      status_type               status;
      logic [OUT_LEN_WIDTH-1:0] length;
   } job_type;

endpackage

`default_nettype wire

[design/cfd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cfd_front #(
   parameter int LEN_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [cfd_pkg::BYTE_WIDTH-1:0] req_in_byte,
   input  wire logic                         req_frame_last,
   input  wire logic                         csr_wr_en,
   input  wire logic [cfd_pkg::CSR_WIDTH-1:0] csr_wr_data,
   output      logic                         job_push,
   output      cfd_pkg::job_type             job_data,
   input  wire logic                         queue_full
);
   import cfd_pkg::*;

   localparam int CW = (LEN_WIDTH > CSR_WIDTH) ? LEN_WIDTH : CSR_WIDTH;
   localparam logic [LEN_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [CW-1:0] COUNT_MAX_EXT = CW'(COUNT_MAX);
   localparam logic [CW-1:0] CSR_RESET_EXT = CW'(CSR_RESET);
   localparam logic [LEN_WIDTH-1:0] LIMIT_RESET =
      LEN_WIDTH'((CSR_RESET_EXT < COUNT_MAX_EXT) ? CSR_RESET_EXT : COUNT_MAX_EXT);

   logic [BYTE_WIDTH-1:0] left_ff, left_in;
   logic                  full_ff, full_in;
   logic                  seen_ff, seen_in;
   logic [LEN_WIDTH-1:0]  count_ff, count_in;
   status_type            err_ff, err_in;
   logic [LEN_WIDTH-1:0]  limit_ff, limit_in;
   logic [CW-1:0]         csr_ext;
   logic                  accept;
   logic                  at_limit;
   logic                  emit;
   logic [BYTE_WIDTH-1:0] emit_byte;
   status_type            final_status;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign at_limit  = count_ff >= limit_ff;

   // The effective capacity is the smaller of the register and the counter range,
   // so it is worked out once when the register is written.
   assign csr_ext  = CW'(csr_wr_data);
   assign limit_in = LEN_WIDTH'((csr_ext < COUNT_MAX_EXT) ? csr_ext : COUNT_MAX_EXT);

   always_comb begin
      err_in       = err_ff;
      left_in      = left_ff;
      full_in      = full_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      emit_byte    = '0;
      final_status = STATUS_OK;
      if (err_ff == STATUS_OK) begin
         if (left_ff == '0) begin
            // A new code byte closes the previous block with an implicit zero
            // unless that block was a full one.
            if (seen_ff && !full_ff) begin
               if (at_limit) begin
                  err_in = STATUS_OVERFLOW;
               end else begin
                  emit     = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            if (err_in == STATUS_OK) begin
               if (req_in_byte == '0) begin
                  err_in = STATUS_ZERO_CODE;
               end else begin
                  left_in = req_in_byte - 1'b1;
                  full_in = (req_in_byte == FULL_CODE);
                  seen_in = 1'b1;
               end
            end
         end else begin
            if (req_in_byte == '0) begin
               err_in = STATUS_ZERO_IN_BLOCK;
            end else if (at_limit) begin
               err_in = STATUS_OVERFLOW;
            end else begin
               emit      = 1'b1;
               emit_byte = req_in_byte;
               count_in  = count_ff + 1'b1;
               left_in   = left_ff - 1'b1;
            end
         end
      end
      final_status = err_in;
      if (err_in == STATUS_OK && left_in != '0) begin
         final_status = STATUS_TRUNCATED;
      end
      job_data.data_vld = emit;
      job_data.data     = emit_byte;
      job_data.done_vld = req_frame_last;
      job_data.status   = final_status;
      job_data.length   = OUT_LEN_WIDTH'(count_in);
      if (req_frame_last) begin
         err_in   = STATUS_OK;
         left_in  = '0;
         full_in  = 1'b0;
         seen_in  = 1'b0;
         count_in = '0;
      end
   end

   assign job_push = accept && (emit || req_frame_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff   <= STATUS_OK;
         left_ff  <= '0;
         full_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (accept) begin
            err_ff   <= err_in;
            left_ff  <= left_in;
            full_ff  <= full_in;
            seen_ff  <= seen_in;
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            limit_ff <= limit_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_last |=> count_ff == '0 && err_ff == STATUS_OK && !seen_ff)
      else $error("frame state not cleared after frame end");
   a_block_needs_code: assert property (@(posedge clock) disable iff (reset)
      left_ff != '0 |-> seen_ff)
      else $error("literal bytes owed without a code byte");
   a_no_data_after_error: assert property (@(posedge clock) disable iff (reset)
      err_ff != STATUS_OK |-> !job_data.data_vld)
      else $error("data byte produced after an error");
`endif

endmodule

`default_nettype wire

[design/cfd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module cfd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cfd_pkg::job_type push_data,
   output      logic             full,
   input  wire logic             pop,
   output      cfd_pkg::job_type pop_data,
   output      logic             empty
);
   import cfd_pkg::*;

   job_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign full     = count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue occupancy beyond its depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("request pushed into a full queue");
`endif

endmodule

`default_nettype wire

[design/cfd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cfd_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire cfd_pkg::job_type                 job_data,
   input  wire logic                             queue_empty,
   output      logic                             job_pop,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [cfd_pkg::BYTE_WIDTH-1:0]   rsp_out_byte,
   output      logic                             rsp_is_data,
   output      logic                             rsp_frame_done,
   output      logic [2:0]                       rsp_status,
   output      logic [cfd_pkg::OUT_LEN_WIDTH-1:0] rsp_decoded_length
);
   import cfd_pkg::*;

   job_type cur_ff;
   logic    data_pend_ff, data_pend_in;
   logic    done_pend_ff, done_pend_in;
   logic    rsp_fire;
   logic    last_result;

   assign rsp_valid   = data_pend_ff || done_pend_ff;
   assign rsp_fire    = rsp_valid && rsp_ready;
   // The current request is finished once its final pending result is taken.
   assign last_result = !(data_pend_ff && done_pend_ff);
   assign job_pop     = !queue_empty && (!rsp_valid || (rsp_fire && last_result));

   always_comb begin
      data_pend_in = data_pend_ff;
      done_pend_in = done_pend_ff;
      if (job_pop) begin
         data_pend_in = job_data.data_vld;
         done_pend_in = job_data.done_vld;
      end else if (rsp_fire) begin
         if (data_pend_ff) begin
            data_pend_in = 1'b0;
         end else begin
            done_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_pend_ff <= 1'b0;
         done_pend_ff <= 1'b0;
      end else begin
         data_pend_ff <= data_pend_in;
         done_pend_ff <= done_pend_in;
      end
   end

   assign rsp_out_byte       = data_pend_ff ? cur_ff.data : '0;
   assign rsp_is_data        = data_pend_ff;
   assign rsp_frame_done     = !data_pend_ff && done_pend_ff;
   assign rsp_status         = data_pend_ff ? STATUS_OK : cur_ff.status;
   assign rsp_decoded_length = data_pend_ff ? '0 : cur_ff.length;

`ifndef SYNTHESIS
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_is_data, rsp_frame_done}))
      else $error("result is neither or both of data and status");
`endif

endmodule

`default_nettype wire

[design/cobs_frame_decoder.sv]
// Streaming COBS decoder.
// Request channel (req_valid/req_ready): one encoded byte per request, with
// req_frame_last marking the final byte of a frame. Response channel
// (rsp_valid/rsp_ready): a request yields up to two responses, a decoded byte
// (rsp_is_data) and, on the last byte of a frame, one status response
// (rsp_frame_done) with the error code and the decoded length.
// csr_wr_en/csr_wr_data set the per-frame output capacity; write it only while
// the block is idle.
// The first response of a request is registered in the queue and then in the
// back end before it is valid. Throughput: one request per cycle while rsp_ready
// stays high and each request yields at most one response; a request that yields
// two responses uses the response port twice, which is the limiting resource.
// The front end works out the frame state update combinationally and feeds a
// two-entry queue; the back end drains it, so the request side keeps accepting
// while a response waits. When rsp_ready is low, the back end holds one request
// and the queue two more, after which req_ready drops.
// Reset clears the frame state, empties the queue and sets the capacity to
// 65535 (or the counter range if smaller).
`timescale 1ns / 1ps
`default_nettype none

module cobs_frame_decoder #(
   parameter int LEN_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [cfd_pkg::BYTE_WIDTH-1:0]    req_in_byte,
   input  wire logic                              req_frame_last,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [cfd_pkg::BYTE_WIDTH-1:0]    rsp_out_byte,
   output      logic                              rsp_is_data,
   output      logic                              rsp_frame_done,
   output      logic [2:0]                        rsp_status,
   output      logic [cfd_pkg::OUT_LEN_WIDTH-1:0] rsp_decoded_length,
   input  wire logic                              csr_wr_en,
   input  wire logic [cfd_pkg::CSR_WIDTH-1:0]     csr_wr_data
);
   import cfd_pkg::*;

   logic    job_push;
   job_type job_in;
   logic    queue_full;
   logic    job_pop;
   job_type job_out;
   logic    queue_empty;

   cfd_front #(
      .LEN_WIDTH(LEN_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_frame_last(req_frame_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .job_push      (job_push),
      .job_data      (job_in),
      .queue_full    (queue_full)
   );

   cfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(job_in),
      .full     (queue_full),
      .pop      (job_pop),
      .pop_data (job_out),
      .empty    (queue_empty)
   );

   cfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_data          (job_out),
      .queue_empty       (queue_empty),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_data       (rsp_is_data),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_status        (rsp_status),
      .rsp_decoded_length(rsp_decoded_length)
   );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import cfd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 120;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_BYTES  = 100;

   typedef logic [BYTE_WIDTH-1:0] byte_queue_type[$];

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]    out_byte;
      logic                     is_data;
      logic                     frame_done;
      status_type               status;
      logic [OUT_LEN_WIDTH-1:0] length;
   } decoded_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_in_byte;
   logic                       req_frame_last;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [BYTE_WIDTH-1:0]      rsp_out_byte;
   logic                       rsp_is_data;
   logic                       rsp_frame_done;
   logic [2:0]                 rsp_status;
   logic [OUT_LEN_WIDTH-1:0]   rsp_decoded_length;
   logic                       csr_wr_en;
   logic [CSR_WIDTH-1:0]       csr_wr_data;

   logic                       rcv_ready;
   logic                       rcv_hold;
   bit                         gaps_on = 1'b1;
   event                       start_hold;
   int                         cycle_count = 0;
   int                         bad_rsp_count = 0;
   int                         live_bytes = 0;

   // Shadow of the decoder state, updated as each request is accepted.
   decoded_rsp_type            decoded_q[$];
   logic [CSR_WIDTH-1:0]       capacity;
   logic [7:0]                 blk_left;
   bit                         prev_full;
   bit                         block_open;
   logic [OUT_LEN_WIDTH-1:0]   out_cnt;
   status_type                 frame_err;

   assign rsp_ready = rcv_ready & ~rcv_hold;

   cobs_frame_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_frame_last     (req_frame_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_data        (rsp_is_data),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_status         (rsp_status),
      .rsp_decoded_length (rsp_decoded_length),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void clear_frame();
      blk_left   = '0;
      prev_full  = 1'b0;
      block_open = 1'b0;
      out_cnt    = '0;
      frame_err  = STATUS_OK;
   endfunction

   function automatic void emit_byte(logic [BYTE_WIDTH-1:0] b);
      if (out_cnt >= capacity) begin
         frame_err = STATUS_OVERFLOW;
      end else begin
         decoded_q.push_back(decoded_rsp_type'{b, 1'b1, 1'b0, STATUS_OK, '0});
         out_cnt++;
      end
   endfunction

   function automatic void decode_byte(logic [BYTE_WIDTH-1:0] b, logic last);
      if (frame_err == STATUS_OK) begin
         if (blk_left == 0) begin
            // A new code byte closes the previous block with a zero, unless it was full.
            if (block_open && !prev_full)
               emit_byte('0);
            if (frame_err == STATUS_OK) begin
               if (b == 0) begin
                  frame_err = STATUS_ZERO_CODE;
               end else begin
                  blk_left   = b - 8'd1;
                  prev_full  = (b == FULL_CODE);
                  block_open = 1'b1;
               end
            end
         end else if (b == 0) begin
            frame_err = STATUS_ZERO_IN_BLOCK;
         end else begin
            emit_byte(b);
            if (frame_err == STATUS_OK)
               blk_left--;
         end
      end
      if (last) begin
         if (frame_err == STATUS_OK && blk_left != 0)
            frame_err = STATUS_TRUNCATED;
         decoded_q.push_back(decoded_rsp_type'{'0, 1'b0, 1'b1, frame_err, out_cnt});
         clear_frame();
      end
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         bad_rsp_count++;
      end
   endfunction

   always @(posedge clock) begin
      decoded_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got byte 0x%0h status %0d",
                     $time, rsp_out_byte, rsp_status);
            bad_rsp_count++;
         end else begin
            want = decoded_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("is_data", want.is_data, rsp_is_data);
            check_field("frame_done", want.frame_done, rsp_frame_done);
            check_field("status", want.status, rsp_status);
            check_field("decoded_length", want.length, rsp_decoded_length);
         end
      end
   end

   initial begin : receiver
      int gap;
      rcv_ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         gap = gaps_on ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            rcv_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rcv_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         @(negedge clock);
      end
   end

   // A long stall of the response side, so that the internal queue fills up.
   initial begin : long_hold
      rcv_hold = 1'b0;
      forever begin
         @(start_hold);
         @(negedge clock);
         rcv_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         rcv_hold <= 1'b0;
      end
   end

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
      int gap;
      gap = gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_frame_last <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (frame_err == STATUS_OK)
         live_bytes++;
      decode_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_frame(input byte_queue_type frame);
      for (int i = 0; i < frame.size(); i++)
         send_byte(frame[i], i == frame.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CSR_WIDTH-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed frames; some are cut short, some carry a stray zero,
   // and some are plain noise.
   task automatic send_random_frame();
      byte_queue_type frame;
      int      kind;
      int      code;
      int      cut;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         repeat ($urandom_range(1, 8))
            frame.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            code = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
            frame.push_back(8'(code));
            repeat (code - 1) frame.push_back(8'($urandom_range(1, 255)));
         end
         if (kind == 7) begin
            cut = $urandom_range(1, frame.size());
            frame = frame[0:cut-1];
         end
         if (kind == 8)
            frame[$urandom_range(0, frame.size() - 1)] = 8'h00;
      end
      send_frame(frame);
   endtask

   task automatic test_plain_frames();
      send_frame({8'h01});
      send_frame({8'h03, 8'h11, 8'h22, 8'h02, 8'hFF, 8'h01});
   endtask

   task automatic test_error_frames();
      send_frame({8'h00, 8'hAA});
      // The zero that closes a block still goes out before a zero code is seen.
      send_frame({8'h02, 8'h11, 8'h00, 8'h05});
      send_frame({8'h03, 8'h11, 8'h00, 8'h22});
      send_frame({8'h04, 8'h11, 8'h22});
   endtask

   task automatic test_capacity();
      set_capacity(16'd2);
      send_frame({8'h05, 8'h01, 8'h02, 8'h03, 8'h04});
      send_frame({8'h03, 8'hAA, 8'hBB, 8'h01});
      set_capacity(16'd1);
      // Capacity is checked for the implicit zero before the code byte itself.
      send_frame({8'h02, 8'h7F, 8'h00});
      set_capacity(16'd0);
      send_frame({8'h01, 8'h01});
      set_capacity(16'hFFFF);
   endtask

   task automatic test_full_block();
      byte_queue_type frame;
      frame.push_back(FULL_CODE);
      repeat (254) frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(8'h03);
      frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(8'($urandom_range(1, 255)));
      send_frame(frame);
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      -> start_hold;
      repeat (6) send_random_frame();
      drain();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int target;
      target = live_bytes + RANDOM_BYTES;
      while (live_bytes < target) begin
         case ($urandom_range(0, 4))
            0:       set_capacity(16'd0);
            1:       set_capacity(16'hFFFF);
            default: set_capacity(16'($urandom_range(1, 40)));
         endcase
         repeat (6) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_frame();
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = '0;
      req_frame_last = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      capacity       = CSR_RESET;
      clear_frame();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_plain_frames();
      test_error_frames();
      test_capacity();
      test_full_block();
      test_backpressure();
      test_random_frames();

      drain();
      if (bad_rsp_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
